>>> hw/rtl/rrpq_pkg.sv
// ----------------------------------------------------------------------------
// rrpq_pkg: shared types and constants of the ranked record priority queue
// Holds the record layout, the opcodes, the per-cycle control bundle handed
// to every cell and the ranking function.
// ----------------------------------------------------------------------------
package rrpq_pkg;

    localparam int FIELD_W = 16;
    localparam int REC_W   = 3 * FIELD_W;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PEEK = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] roll;
        logic [FIELD_W-1:0] marks;
    } t_rec;

    // Broadcast to all cells in the cycle an item is transferred.
    typedef struct packed {
        logic push;
        logic pop;
        t_rec rec;
    } t_cell_ctl;

    // True when record a ranks strictly above record b.
    function automatic logic ranks_above(input t_rec a, input t_rec b);
        logic res;
        if (a.marks != b.marks) begin
            res = (a.marks > b.marks);
        end else begin
            res = (a.roll < b.roll);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/ranked_record_priority_queue.sv
// ----------------------------------------------------------------------------
// ranked_record_priority_queue: bounded priority queue on a sorted cell line
// Every cell compares and shifts in parallel. Each report is registered and
// held until taken; one item per cycle while no report waits untaken.
// Reset: synchronous, active low; clears the fill count, the overflow flag
// and the output valid. Cell contents are not reset and are never read free.
// ----------------------------------------------------------------------------
module ranked_record_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // tag [15:0], roll [31:16], marks [47:32]
    input  logic [1:0]  i_s_axis_tuser,   // opcode [1:0]
    // Master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // top_tag [15:0], top_roll [31:16],
                                          // top_marks [47:32]
    output logic [1:0]  o_m_axis_tuser    // is_empty [0], overflowed [1]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int FW    = rrpq_pkg::FIELD_W;

    // Control state.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    logic [47:0]      r_out_data;
    logic [1:0]       r_out_user;

    logic                w_accept;
    logic [1:0]          w_op;
    logic                w_is_push;
    logic                w_full;
    logic                w_empty_next;
    rrpq_pkg::t_cell_ctl w_ctl;
    rrpq_pkg::t_rec      w_new_rec;
    rrpq_pkg::t_rec      w_top_next;

    rrpq_pkg::t_rec w_rec  [CAPACITY];
    rrpq_pkg::t_rec w_next [CAPACITY];
    logic           w_gt   [CAPACITY];

    // The output register frees the input side as long as the pending
    // report is taken in the same cycle or there is none.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_op            = i_s_axis_tuser;
    assign w_new_rec.tag   = i_s_axis_tdata[FW-1:0];
    assign w_new_rec.roll  = i_s_axis_tdata[2*FW-1:FW];
    assign w_new_rec.marks = i_s_axis_tdata[3*FW-1:2*FW];

    assign w_is_push = (w_op == rrpq_pkg::OP_PUSH) || (w_op == rrpq_pkg::OP_LOAD);
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    // A push into a full line is dropped; a pop of an empty line does nothing.
    assign w_ctl.push = w_accept && w_is_push && !w_full;
    assign w_ctl.pop  = w_accept && (w_op == rrpq_pkg::OP_POP) && (r_count != '0);
    assign w_ctl.rec  = w_new_rec;

    // Each cell looks at its left neighbor for the insert shift and at its
    // right neighbor for the pop shift.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rrpq_pkg::t_rec w_left_rec;
        rrpq_pkg::t_rec w_right_rec;
        logic           w_left_gt;

        if (g == 0) begin : g_first
            assign w_left_rec = w_new_rec;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid
            assign w_left_rec = w_rec[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_rec = '0;
        end else begin : g_inner
            assign w_right_rec = w_rec[g+1];
        end

        rrpq_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left_rec  (w_left_rec),
            .i_left_gt   (w_left_gt),
            .i_right_rec (w_right_rec),
            .o_rec       (w_rec[g]),
            .o_gt        (w_gt[g]),
            .o_next_rec  (w_next[g])
        );
    end

    // Only the head cell's next value feeds the report.
    assign w_top_next = w_next[0];

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign n_ovf        = r_ovf || (w_accept && w_is_push && w_full);
    assign w_empty_next = (n_count == '0);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && (w_op != rrpq_pkg::OP_LOAD)) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // The report reflects the line after this transfer, so it is taken from
    // the head cell's next value.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op != rrpq_pkg::OP_LOAD)) begin
            if (w_empty_next) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {w_top_next.marks, w_top_next.roll, w_top_next.tag};
            end
            r_out_user <= {n_ovf, w_empty_next};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // The fill count never passes the line length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // Once set, the overflow flag stays set until reset.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    // An empty report carries an all-zero record.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("empty report with record data");

    // A pop of a non-empty line takes exactly one record away.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement fill count");

endmodule

>>> hw/rtl/rrpq_cell.sv
// ----------------------------------------------------------------------------
// rrpq_cell: one slot of the sorted record line
// Compares the incoming record with its own, then keeps its record, takes the
// new one, takes its left neighbor's (insert shift) or its right one's (pop).
// ----------------------------------------------------------------------------
module rrpq_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  rrpq_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  rrpq_pkg::t_rec      i_left_rec,
    input  logic                i_left_gt,
    input  rrpq_pkg::t_rec      i_right_rec,
    output rrpq_pkg::t_rec      o_rec,
    output logic                o_gt,
    output rrpq_pkg::t_rec      o_next_rec
);

    rrpq_pkg::t_rec r_rec;
    rrpq_pkg::t_rec n_rec;
    logic           w_occupied;

    // Free cells always accept the new record, so the insert point is the
    // first cell whose flag is set.
    assign w_occupied = (CNT_W'(IDX) < i_count);
    assign o_gt       = !w_occupied || rrpq_pkg::ranks_above(i_ctl.rec, r_rec);

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.push && o_gt) begin
            n_rec = i_left_gt ? i_left_rec : i_ctl.rec;
        end else if (i_ctl.pop) begin
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec      = r_rec;
    assign o_next_rec = n_rec;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the ranked record priority queue
// Runs directed corner cases, random traffic, back-pressure and overflow tests.
// Its own sorted-line predictor computes the top report that each transfer
// should produce, and every output transfer is compared with it field by
// field. Random bursts on the input, a stall pattern on the output and one
// long hold-off that fills the block up exercise the stream handshakes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUEUE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;

    // One expected report, as the master side should deliver it.
    typedef struct packed {
        logic           is_empty;
        rrpq_pkg::t_rec top;
        logic           overflowed;
    } t_top_report;

    // Everything the block sees starts at a known value.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata  = '0;   // tag [15:0], roll [31:16], marks [47:32]
    logic [1:0]  i_s_axis_tuser  = '0;   // opcode [1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;         // top_tag [15:0], top_roll [31:16],
                                         // top_marks [47:32]
    logic [1:0]  o_m_axis_tuser;         // is_empty [0], overflowed [1]

    ranked_record_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Predicted contents of the queue, best record first, and the sticky flag.
    rrpq_pkg::t_rec ranked_recs[$];
    logic           overflow_sticky = 1'b0;
    // Reports still owed by the block, oldest first.
    t_top_report pending_reports[$];
    t_top_report oldest_report;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Sender pacing: bursts of random length, each preceded by a random gap
    // when idling is enabled.
    bit tx_idle_en  = 1'b1;
    int burst_left  = 0;

    // Receiver pacing: a rotating 16-bit stall pattern, or a long hold-off.
    bit          rx_stall_en = 1'b1;
    int          hold_left   = 0;
    logic [15:0] rx_pattern  = 16'hFFFF;
    int          rx_idx      = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A record outranks another on a higher mark, then on a lower roll.
    function automatic bit outranks(rrpq_pkg::t_rec a, rrpq_pkg::t_rec b);
        if (a.marks != b.marks) begin
            return a.marks > b.marks;
        end
        return a.roll < b.roll;
    endfunction

    // Applies one accepted item to the predicted queue and queues the report
    // it causes. An equal-ranked newcomer goes behind the records already
    // held, so the earliest of a tie stays on top.
    function automatic void apply_item(logic [1:0] op, rrpq_pkg::t_rec rec);
        int          pos;
        t_top_report rpt;
        pos = 0;
        if (op == rrpq_pkg::OP_PUSH || op == rrpq_pkg::OP_LOAD) begin
            if (ranked_recs.size() >= QUEUE_DEPTH) begin
                overflow_sticky = 1'b1;
            end else begin
                while (pos < ranked_recs.size() && !outranks(rec, ranked_recs[pos]))
                    pos++;
                ranked_recs.insert(pos, rec);
            end
        end else if (op == rrpq_pkg::OP_POP && ranked_recs.size() > 0) begin
            void'(ranked_recs.pop_front());
        end
        // A silent load is the only operation that owes no report.
        if (op != rrpq_pkg::OP_LOAD) begin
            rpt.is_empty   = (ranked_recs.size() == 0);
            rpt.top        = '0;
            rpt.overflowed = overflow_sticky;
            if (!rpt.is_empty) begin
                rpt.top = ranked_recs[0];
            end
            pending_reports.push_back(rpt);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic rrpq_pkg::t_rec make_rec(logic [15:0] tag, logic [15:0] roll,
                                                logic [15:0] marks);
        rrpq_pkg::t_rec r;
        r.tag   = tag;
        r.roll  = roll;
        r.marks = marks;
        return r;
    endfunction

    // Mostly fully random records; a share of them is drawn from a narrow
    // band so that equal marks and full ties keep showing up, and a few sit
    // on the field extremes.
    function automatic rrpq_pkg::t_rec random_record();
        rrpq_pkg::t_rec r;
        int             style;
        style = $urandom_range(0, 9);
        r.tag = 16'($urandom);
        if (style < 3) begin
            r.marks = 16'h7FFE + 16'($urandom_range(0, 3));
            r.roll  = 16'($urandom_range(0, 3));
        end else if (style == 3) begin
            r.marks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            r.roll  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            r.marks = 16'($urandom);
            r.roll  = 16'($urandom);
        end
        return r;
    endfunction

    // Opcode mix by traffic phase: 0 grows the queue, 1 drains it,
    // anything else keeps it roughly level.
    function automatic logic [1:0] pick_op(int bias);
        int dice;
        dice = $urandom_range(0, 99);
        if (bias == 0) begin
            if (dice < 40) return rrpq_pkg::OP_PUSH;
            if (dice < 70) return rrpq_pkg::OP_LOAD;
            if (dice < 80) return rrpq_pkg::OP_PEEK;
            return rrpq_pkg::OP_POP;
        end else if (bias == 1) begin
            if (dice < 20) return rrpq_pkg::OP_PUSH;
            if (dice < 30) return rrpq_pkg::OP_LOAD;
            if (dice < 45) return rrpq_pkg::OP_PEEK;
            return rrpq_pkg::OP_POP;
        end
        if (dice < 25) return rrpq_pkg::OP_PUSH;
        if (dice < 50) return rrpq_pkg::OP_LOAD;
        if (dice < 75) return rrpq_pkg::OP_PEEK;
        return rrpq_pkg::OP_POP;
    endfunction

    // Offers one item and returns at the rising edge where its transfer took
    // place. Ready is sampled at the falling edge, where everything is
    // settled, and the transfer then happens at the next rising edge.
    task automatic send_item(logic [1:0] op, rrpq_pkg::t_rec rec);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = tx_idle_en ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rec.marks, rec.roll, rec.tag};
        i_s_axis_tuser  <= op;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_s_axis_tready === 1'b1);
            @(posedge i_clk);
        end
        apply_item(op, rec);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases: reports on an empty queue, field extremes, the tie
    // breaking on roll, first-in-first-out order among equal records, silent
    // loads, ignored fields on peek and pop, and popping past empty.
    task automatic test_directed();
        send_item(rrpq_pkg::OP_PEEK, make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(rrpq_pkg::OP_POP,  make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'h0000, 16'h0000, 16'h0000));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'h1111, 16'h0000, 16'hFFFF));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'h2222, 16'h0000, 16'hFFFF));
        send_item(rrpq_pkg::OP_LOAD, make_rec(16'h3333, 16'h0005, 16'h8000));
        send_item(rrpq_pkg::OP_PEEK, make_rec(16'h0000, 16'h0000, 16'h0000));
        repeat (6) send_item(rrpq_pkg::OP_POP, make_rec(16'hA5A5, 16'h5A5A, 16'hFFFF));
        send_item(rrpq_pkg::OP_LOAD, make_rec(16'hAAAA, 16'h5555, 16'h5555));
        send_item(rrpq_pkg::OP_LOAD, make_rec(16'h5555, 16'hAAAA, 16'hAAAA));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'h0F0F, 16'hAAAA, 16'hAAAA));
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'hF0F0, 16'h5554, 16'h5555));
        send_item(rrpq_pkg::OP_PEEK, make_rec(16'h1234, 16'h5678, 16'h9ABC));
        repeat (5) send_item(rrpq_pkg::OP_POP, make_rec(16'h0000, 16'hFFFF, 16'h0000));
    endtask

    // Phases of random traffic that alternately grow, hold and drain the
    // queue. Pushes are kept off a full queue here so that the overflow flag
    // stays clear until the overflow test sets it on purpose.
    task automatic test_random_traffic(int n_phases, int per_phase);
        int         bias;
        logic [1:0] op;
        for (int p = 0; p < n_phases; p++) begin
            bias        = (p % 4 == 3) ? 2 : (p % 2);
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < per_phase; i++) begin
                op = pick_op(bias);
                if ((op == rrpq_pkg::OP_PUSH || op == rrpq_pkg::OP_LOAD)
                        && ranked_recs.size() >= QUEUE_DEPTH)
                    op = rrpq_pkg::OP_POP;
                send_item(op, random_record());
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering reporting items back to back, so the block fills its output
    // and must stall its input until the receiver resumes.
    task automatic test_backpressure();
        logic [1:0] op;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b1;
        hold_left   = 300;
        for (int i = 0; i < 48; i++) begin
            op = (i % 2 == 0) ? rrpq_pkg::OP_PUSH : rrpq_pkg::OP_PEEK;
            if (ranked_recs.size() >= QUEUE_DEPTH)
                op = rrpq_pkg::OP_PEEK;
            send_item(op, random_record());
        end
        tx_idle_en = 1'b1;
    endtask

    // Fills the queue with silent loads, then pushes and loads into the full
    // queue: both are dropped, the push still reports the unchanged top and
    // the overflow flag turns on for good. Then it drains past empty.
    task automatic test_overflow();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        while (ranked_recs.size() < QUEUE_DEPTH)
            send_item(rrpq_pkg::OP_LOAD, random_record());
        send_item(rrpq_pkg::OP_PUSH, make_rec(16'hBEEF, 16'h0000, 16'hFFFF));
        send_item(rrpq_pkg::OP_LOAD, make_rec(16'hCAFE, 16'h0000, 16'hFFFF));
        send_item(rrpq_pkg::OP_PEEK, random_record());
        repeat (QUEUE_DEPTH + 2) send_item(rrpq_pkg::OP_POP, random_record());
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    // Ready is driven at the rising edge. A pending hold-off wins; with stalls
    // off ready stays high, else the pattern rotates and is redrawn when it wraps,
    // now and then as a stretch with no stalls at all.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else if (!rx_stall_en) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= rx_pattern[rx_idx];
            rx_idx = (rx_idx + 1) % 16;
            if (rx_idx == 0)
                rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
    end

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    function automatic void check_field(string name, logic [15:0] expv,
                                        logic [15:0] actv);
        if (actv !== expv)
            note_failure($sformatf("mismatch in %s: expected %h, got %h",
                                   name, expv, actv));
    endfunction

    // Outputs are sampled at the falling edge; a transfer seen there is the
    // one that completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected report: tdata %h, tuser %b",
                                       o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                oldest_report = pending_reports.pop_front();
                check_field("is_empty", 16'(oldest_report.is_empty),
                            16'(o_m_axis_tuser[0]));
                check_field("top_tag", oldest_report.top.tag, o_m_axis_tdata[15:0]);
                check_field("top_roll", oldest_report.top.roll, o_m_axis_tdata[31:16]);
                check_field("top_marks", oldest_report.top.marks, o_m_axis_tdata[47:32]);
                check_field("overflowed", 16'(oldest_report.overflowed),
                            16'(o_m_axis_tuser[1]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(10, 80);
        test_backpressure();
        test_overflow();
        test_random_traffic(4, 70);

        i_s_axis_tvalid <= 1'b0;
        // Drain the owed reports, then give the registered output time
        // to show any stray transfer.
        while (pending_reports.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
